@@ hw/rtl/bis_pkg.sv @@
// Shared types and codes for the bounded integer stack with search.
`default_nettype none

package bis_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CNT_W   = 9;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_SEARCH = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } fsm_t;

endpackage

`default_nettype wire

@@ hw/rtl/bis_if.sv @@
// Valid/ready channel interfaces for the stack's action and result beats.
`default_nettype none

interface bis_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bis_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         found_index;
  logic [8:0]         item_count;
  logic               empty_flag;
  logic               full_flag;

  modport source (output valid, output status, output read_value, output found_index,
                  output item_count, output empty_flag, output full_flag, input ready);
  modport sink   (input valid, input status, input read_value, input found_index,
                  input item_count, input empty_flag, input full_flag, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bis_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/bounded_int_stack_with_search.sv @@
// Bounded LIFO stack of signed 32-bit words with top-down search.
// Each input beat is one action (push, pop, peek, clear, search) and gives one
// result beat carrying status, popped/peeked word, match index, count and the
// empty/full flags. Entries live in one RAM with a registered read port.
// Push, clear, unknown actions and failing actions give their result from idle;
// pop and peek pass through S_READ for the RAM read; search reads one entry a
// cycle from the top down in S_SCAN (at most count entries), then goes to S_DONE.
// A new action is taken once the previous one has finished and the result
// register is free or being emptied. capacity resets to 256 and is clipped to
// DEPTH; no clearing pass is needed after reset.
`default_nettype none

module bounded_int_stack_with_search
  import bis_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bis_in_if.sink              in_ch,
  bis_out_if.source           out_ch,
  input  wire logic           cfg_we,
  input  wire logic [8:0]     cfg_wdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;

  fsm_t                state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAP_W-1:0]    capacity_r;
  logic [AW-1:0]       cmp_r, cmp_nxt;
  logic [VALUE_W-1:0]  key_r, key_nxt;
  logic                is_pop_r, is_pop_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [AW-1:0]       res_idx_r, res_idx_nxt;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [VALUE_W-1:0]  out_rd_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_empty_r;
  logic                out_full_r;

  logic                out_free;
  logic                in_fire;
  logic                load_out;
  status_t             ld_status;
  logic [VALUE_W-1:0]  ld_rd;
  logic [AW-1:0]       ld_idx;

  logic                mem_we;
  logic [AW-1:0]       mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;
  logic [AW-1:0]       top_addr;

  logic [MW-1:0]       eff_cap;
  logic [MW-1:0]       cap_ext;
  logic [MW-1:0]       depth_ext;
  logic [MW-1:0]       count_ext;
  logic [MW-1:0]       nxt_ext;
  logic [IW-1:0]       idx_ext;

  assign cap_ext   = MW'(capacity_r);
  assign depth_ext = MW'(DEPTH);
  assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign count_ext = MW'(count_r);
  assign nxt_ext   = MW'(count_nxt);
  assign idx_ext   = IW'(ld_idx);
  assign top_addr  = AW'(count_r - CW'(1));

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  bis_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count_r)),
    .wdata (in_ch.value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= CAP_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_r        <= cmp_nxt;
    key_r        <= key_nxt;
    is_pop_r     <= is_pop_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    if (load_out) begin
      out_status_r <= ld_status;
      out_rd_r     <= ld_rd;
      out_idx_r    <= idx_ext[IDX_W-1:0];
      out_count_r  <= nxt_ext[CNT_W-1:0];
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (nxt_ext >= eff_cap);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmp_nxt        = cmp_r;
    key_nxt        = key_r;
    is_pop_nxt     = is_pop_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    mem_we         = 1'b0;
    mem_raddr      = top_addr;
    load_out       = 1'b0;
    ld_status      = ST_OK;
    ld_rd          = '0;
    ld_idx         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            ACT_PUSH: begin
              load_out = 1'b1;
              if (count_ext >= eff_cap) begin
                ld_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (count_r == '0) begin
                load_out  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                is_pop_nxt = (in_ch.action == ACT_POP);
                state_nxt  = S_READ;
              end
            end
            ACT_CLEAR: begin
              load_out  = 1'b1;
              count_nxt = '0;
            end
            ACT_SEARCH: begin
              if (count_r == '0) begin
                load_out  = 1'b1;
                ld_status = ST_NOTFOUND;
              end else begin
                key_nxt   = in_ch.value;
                cmp_nxt   = top_addr;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_rd     = mem_rdata;
          state_nxt = S_IDLE;
          if (is_pop_r) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      S_SCAN: begin
        mem_raddr = cmp_r - AW'(1);
        if (mem_rdata == key_r) begin
          res_status_nxt = ST_OK;
          res_idx_nxt    = cmp_r;
          state_nxt      = S_DONE;
        end else if (cmp_r == '0) begin
          res_status_nxt = ST_NOTFOUND;
          res_idx_nxt    = '0;
          state_nxt      = S_DONE;
        end else begin
          cmp_nxt = cmp_r - AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = res_status_r;
          ld_idx    = res_idx_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.item_count  = out_count_r;
  assign out_ch.empty_flag  = out_empty_r;
  assign out_ch.full_flag   = out_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    MW'(count_r) <= depth_ext)
    else $error("count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.action == ACT_PUSH && count_ext < eff_cap)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the stack");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (MW'(cmp_r) < count_ext))
    else $error("scan index beyond top");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE && in_fire))
    else $error("store written outside an accepted push");

endmodule

`default_nettype wire

@@ tb/sv/bounded_int_stack_with_search_tb.sv @@
// Self-checking testbench for the bounded integer stack with search: directed and random actions.
module bounded_int_stack_with_search_tb;
  import bis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 12;
  localparam longint      TIMEOUT_CYCLES = 2_000_000;
  localparam int          STACK_DEPTH    = 256;
  localparam int          ITEM_TARGET    = 1850;
  localparam int          HOLDOFF_CYCLES = 200;
  localparam logic [2:0]  ACT_RSVD_LO    = 3'd5;
  localparam logic [2:0]  ACT_RSVD_HI    = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [7:0]  found_index;
    logic [8:0]  item_count;
    logic        empty_flag;
    logic        full_flag;
  } stack_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;

  bis_in_if  in_ch ();
  bis_out_if out_ch ();

  bounded_int_stack_with_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [31:0] model_words [STACK_DEPTH];
  int          model_count;
  logic [8:0]  model_capacity;

  stack_result_t pending_results[$];
  int            error_count;
  int            items_sent;
  int            burst_left;
  bit            gaps_enabled;
  int            hold_request;

  function automatic stack_result_t predict_stack_action(input logic [2:0] act,
                                                         input logic [31:0] val);
    stack_result_t r;
    int            eff_cap;
    int            i;
    r = '0;
    r.status = ST_OK;
    eff_cap = (model_capacity > STACK_DEPTH) ? STACK_DEPTH : int'(model_capacity);
    case (act)
      ACT_PUSH: begin
        if (model_count >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          model_words[model_count] = val;
          model_count++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_value = model_words[model_count - 1];
          if (act == ACT_POP) model_count--;
        end
      end
      ACT_CLEAR: model_count = 0;
      ACT_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = model_count - 1; i >= 0; i--) begin
          if (model_words[i] == val) begin
            r.status      = ST_OK;
            r.found_index = i[7:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.item_count = model_count[8:0];
    r.empty_flag = (model_count == 0);
    r.full_flag  = (model_count >= eff_cap);
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return 32'($signed($urandom_range(0, 7)) - 3);
      default: return $urandom;
    endcase
  endfunction

  // Sends one beat and waits for it to be taken; gaps fall between bursts.
  task automatic send_beat(input logic [2:0] act, input logic [31:0] val);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_stack_action(act, val));
    if (act <= ACT_SEARCH) items_sent++;
    if (gaps_enabled) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(0, 40);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_capacity(input logic [8:0] cap);
    drain_idle();
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_capacity = cap;
  endtask

  // Result checker
  always @(posedge clk) begin : check_beat
    stack_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          error_count++;
        end
        if (out_ch.read_value !== exp_r.read_value) begin
          $error("read_value: expected %h, got %h", exp_r.read_value, out_ch.read_value);
          error_count++;
        end
        if (out_ch.found_index !== exp_r.found_index) begin
          $error("found_index: expected %0d, got %0d", exp_r.found_index,
                 out_ch.found_index);
          error_count++;
        end
        if (out_ch.item_count !== exp_r.item_count) begin
          $error("item_count: expected %0d, got %0d", exp_r.item_count, out_ch.item_count);
          error_count++;
        end
        if (out_ch.empty_flag !== exp_r.empty_flag) begin
          $error("empty_flag: expected %0b, got %0b", exp_r.empty_flag, out_ch.empty_flag);
          error_count++;
        end
        if (out_ch.full_flag !== exp_r.full_flag) begin
          $error("full_flag: expected %0b, got %0b", exp_r.full_flag, out_ch.full_flag);
          error_count++;
        end
      end
    end
  end

  // Receiver: shifting stall patterns, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int stall_mode;
    int mode_left;
    int tick;
    hold_left = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        tick++;
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ((tick % 8) >= 3);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic test_empty_stack();
    send_beat(ACT_POP, random_word());
    send_beat(ACT_PEEK, random_word());
    send_beat(ACT_SEARCH, 32'h0000_0000);
  endtask

  task automatic test_push_pop_search();
    logic [2:0] act;
    send_beat(ACT_PUSH, 32'h8000_0000);
    send_beat(ACT_PUSH, 32'h7fff_ffff);
    send_beat(ACT_PUSH, 32'h0000_0000);
    send_beat(ACT_PUSH, 32'hffff_ffff);
    send_beat(ACT_PUSH, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'h0000_3039);
    send_beat(ACT_PEEK, random_word());
    send_beat(ACT_POP, random_word());
    for (act = ACT_RSVD_LO; act != 3'd0; act++) send_beat(act, $urandom);
    send_beat(ACT_CLEAR, random_word());
    send_beat(ACT_SEARCH, 32'hffff_ffff);
  endtask

  // Zero capacity, filling to capacity, and capacity dropped below the count
  task automatic test_capacity_limits();
    set_capacity(9'd0);
    send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_PEEK, $urandom);
    set_capacity(9'd2);
    send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_PUSH, $urandom);
    set_capacity(9'd1);
    send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_POP, $urandom);
    send_beat(ACT_POP, $urandom);
    send_beat(ACT_POP, $urandom);
  endtask

  task automatic test_output_holdoff();
    int k;
    set_capacity(9'd256);
    gaps_enabled = 1'b0;
    hold_request = HOLDOFF_CYCLES;
    for (k = 0; k < 30; k++) begin
      if (k % 3 == 2) send_beat(ACT_PEEK, random_word());
      else send_beat(ACT_PUSH, random_word());
    end
    gaps_enabled = 1'b1;
  endtask

  // Full depth: distinct words, topmost and bottom matches, capacity above depth
  task automatic test_full_depth();
    logic [31:0] base;
    int          k;
    base = $urandom;
    set_capacity(9'd256);
    send_beat(ACT_CLEAR, random_word());
    for (k = 0; k < STACK_DEPTH; k++) send_beat(ACT_PUSH, base + k * 32'h9E37_79B9);
    send_beat(ACT_PUSH, random_word());
    send_beat(ACT_SEARCH, base + (STACK_DEPTH - 1) * 32'h9E37_79B9);
    send_beat(ACT_SEARCH, base);
    send_beat(ACT_SEARCH, base + STACK_DEPTH * 32'h9E37_79B9);
    send_beat(ACT_PEEK, random_word());
    set_capacity(9'd511);
    send_beat(ACT_PUSH, random_word());
    set_capacity(9'd300);
    send_beat(ACT_SEARCH, base + 17 * 32'h9E37_79B9);
    for (k = 0; k <= STACK_DEPTH; k++) send_beat(ACT_POP, random_word());
  endtask

  task automatic test_random_sequences();
    int          phase_len;
    int          push_pct;
    int          k;
    int          r;
    logic [2:0]  act;
    logic [31:0] val;
    logic [8:0]  cap;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:          cap = 9'd0;
        1, 2, 3, 4: cap = 9'($urandom_range(1, 16));
        5, 6:       cap = 9'($urandom_range(17, 64));
        7:          cap = 9'd256;
        8:          cap = 9'($urandom_range(257, 511));
        default:    cap = 9'($urandom_range(65, 255));
      endcase
      set_capacity(cap);
      if ($urandom_range(0, 2) == 0) send_beat(ACT_CLEAR, random_word());
      gaps_enabled = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(20, 120);
      push_pct     = $urandom_range(25, 75);
      for (k = 0; k < phase_len && items_sent < ITEM_TARGET; k++) begin
        val = random_word();
        if ($urandom_range(0, 99) < push_pct) begin
          act = ACT_PUSH;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 35) act = ACT_POP;
          else if (r < 50) act = ACT_PEEK;
          else if (r < 92) act = ACT_SEARCH;
          else if (r < 96) act = ACT_CLEAR;
          else act = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        end
        if (act == ACT_SEARCH && model_count > 0 && $urandom_range(0, 9) < 7)
          val = model_words[$urandom_range(0, model_count - 1)];
        send_beat(act, val);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_PUSH;
    in_ch.value  <= '0;
    out_ch.ready <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    model_count    = 0;
    model_capacity = 9'd256;
    error_count    = 0;
    items_sent     = 0;
    burst_left     = 0;
    gaps_enabled   = 1'b1;
    hold_request   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_push_pop_search();
    test_capacity_limits();
    test_output_holdoff();
    test_full_depth();
    test_random_sequences();

    drain_idle();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("bounded_int_stack_with_search_tb OK");
    end else begin
      $display("bounded_int_stack_with_search_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("bounded_int_stack_with_search_tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bis_pkg.sv
hw/rtl/bis_if.sv
hw/rtl/bis_ram.sv
hw/rtl/bounded_int_stack_with_search.sv
tb/sv/bounded_int_stack_with_search_tb.sv
